@@ rtl/core/gpr_pkg.sv @@
// Shared types and constants of the GPIO port register bank.
package gpr_pkg;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_PIN   = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   localparam logic [3:0] IDX_MODE      = 4'd0;
   localparam logic [3:0] IDX_INPUT     = 4'd4;
   localparam logic [3:0] IDX_OUTPUT    = 4'd5;
   localparam logic [3:0] IDX_SETRESET  = 4'd6;
   localparam logic [3:0] IDX_RESETONLY = 4'd10;

   localparam logic [1:0] MODE_IN  = 2'd0;
   localparam logic [1:0] MODE_OUT = 2'd1;
   localparam logic [1:0] MODE_ALT = 2'd2;

   localparam logic [1:0] EDGE_NONE    = 2'd0;
   localparam logic [1:0] EDGE_RISING  = 2'd1;
   localparam logic [1:0] EDGE_FALLING = 2'd2;

   localparam logic [15:0] HALF_ONES = 16'hFFFF;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_INPUT_MASK = 1'b0;

   typedef struct packed {
      cmd_type     command;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
      logic [3:0]  pin_number;
      logic        pin_level;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] pin_drive;
      logic [15:0] drive_changed;
      logic [15:0] alt_flags;
      logic [15:0] alt_changed;
      logic [1:0]  edge_event;
      logic [3:0]  edge_pin;
      logic        wake_level;
   } rsp_item_type;

   typedef struct packed {
      logic step;
      logic valid;
   } exec_ctrl_type;

endpackage

@@ rtl/core/gpr_csr.sv @@
// Configuration register file holding the reset-time input mask.
module gpr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gpr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output logic [15:0]                    input_mask
);
   import gpr_pkg::*;

   logic [15:0] input_mask_ff;
   logic [15:0] input_mask_in;
   logic        wr_en;
   logic        sel_mask;

   assign pready   = 1'b1;
   assign sel_mask = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_INPUT_MASK);
   assign wr_en    = psel & penable & pwrite & sel_mask;

   always_comb begin
      input_mask_in = input_mask_ff;
      if (wr_en) begin
         input_mask_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_mask_ff <= '0;
      end else begin
         input_mask_ff <= input_mask_in;
      end
   end

   assign prdata     = sel_mask ? {16'd0, input_mask_ff} : 32'd0;
   assign input_mask = input_mask_ff;

endmodule

@@ rtl/core/gpr_exec.sv @@
// Register bank state and the single-pass logic that applies one item to it.
module gpr_exec #(
   parameter int PIN_COUNT = 16,
   parameter int REG_COUNT = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gpr_pkg::exec_ctrl_type ctrl,
   input  gpr_pkg::req_item_type item,
   input  logic [15:0]           input_mask,
   output gpr_pkg::rsp_item_type result
);
   import gpr_pkg::*;

   localparam int IW = $clog2(REG_COUNT);
   localparam logic [15:0] PIN_MASK = 16'((33'd1 << PIN_COUNT) - 33'd1);

   logic [31:0] rf_ff [REG_COUNT];
   logic [31:0] rf_in [REG_COUNT];
   logic [15:0] alt_ff;
   logic [15:0] alt_in;

   always_comb begin
      logic [15:0] odr;
      logic [15:0] old_odr;
      logic [15:0] inr;
      logic [1:0]  m;
      logic [1:0]  pm;
      logic        old_lvl;
      logic        idx_ok;
      logic        pin_ok;

      rf_in   = rf_ff;
      alt_in  = alt_ff;
      result  = '0;
      old_odr = rf_ff[IDX_OUTPUT[IW-1:0]][15:0];
      odr     = old_odr;
      inr     = rf_ff[IDX_INPUT[IW-1:0]][15:0];
      m       = MODE_IN;
      pm      = MODE_IN;
      old_lvl = 1'b0;
      idx_ok  = (32'(item.reg_index) < REG_COUNT);
      pin_ok  = (32'(item.pin_number) < PIN_COUNT);

      case (item.command)
         CMD_READ: begin
            if (idx_ok) begin
               result.read_data = rf_ff[item.reg_index[IW-1:0]];
            end
         end
         CMD_WRITE: begin
            if (idx_ok) begin
               case (item.reg_index)
                  IDX_MODE: begin
                     for (int i = 0; i < PIN_COUNT; i++) begin
                        m  = item.write_data[2*i +: 2];
                        pm = rf_ff[IDX_MODE[IW-1:0]][2*i +: 2];
                        if (m != pm) begin
                           result.alt_changed[i] = 1'b1;
                           alt_in[i] = (m == MODE_ALT);
                           if (m == MODE_IN) begin
                              odr[i] = 1'b1;
                           end else if (m == MODE_OUT) begin
                              odr[i] = 1'b0;
                           end
                        end
                     end
                     rf_in[IDX_MODE[IW-1:0]] = item.write_data;
                  end
                  IDX_OUTPUT: begin
                     odr = item.write_data[15:0];
                  end
                  IDX_SETRESET: begin
                     odr = (odr & ~item.write_data[31:16]) | item.write_data[15:0];
                     inr = (inr & ~item.write_data[31:16]) | item.write_data[15:0];
                  end
                  IDX_RESETONLY: begin
                     odr = odr & ~item.write_data[15:0];
                     inr = inr & ~item.write_data[15:0];
                  end
                  IDX_INPUT: begin
                     odr = old_odr;
                  end
                  default: begin
                     rf_in[item.reg_index[IW-1:0]] = item.write_data;
                  end
               endcase
               rf_in[IDX_OUTPUT[IW-1:0]] = {16'd0, odr};
               rf_in[IDX_INPUT[IW-1:0]]  = {16'd0, inr};
               result.drive_changed      = (old_odr ^ odr) & PIN_MASK;
            end
         end
         CMD_PIN: begin
            if (pin_ok) begin
               old_lvl = inr[item.pin_number];
               inr[item.pin_number] = item.pin_level;
               rf_in[IDX_INPUT[IW-1:0]] = {16'd0, inr};
               if (!old_lvl && item.pin_level) begin
                  result.edge_event = EDGE_RISING;
               end else if (old_lvl && !item.pin_level) begin
                  result.edge_event = EDGE_FALLING;
               end
               if (result.edge_event != EDGE_NONE) begin
                  result.edge_pin = item.pin_number;
               end
               result.wake_level = item.pin_level;
            end
         end
         default: begin
            for (int r = 0; r < REG_COUNT; r++) begin
               rf_in[r] = '0;
            end
            rf_in[IDX_INPUT[IW-1:0]] = {16'd0, HALF_ONES & ~input_mask};
         end
      endcase

      result.pin_drive = rf_in[IDX_OUTPUT[IW-1:0]][15:0];
      result.alt_flags = alt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REG_COUNT; r++) begin
            rf_ff[r] <= '0;
         end
         rf_ff[IDX_INPUT[IW-1:0]] <= {16'd0, HALF_ONES};
         alt_ff <= '0;
      end else if (ctrl.step && ctrl.valid) begin
         rf_ff  <= rf_in;
         alt_ff <= alt_in;
      end
   end

endmodule

@@ rtl/core/gpio_port_register_bank.sv @@
// Top level of the GPIO port register bank: channels, pipeline registers and configuration.
//
// Items arrive on the req_ channel (req_valid / req_stall) and each gives exactly
// one result on the rsp_ channel (rsp_valid / rsp_stall). A transfer happens at a
// rising edge where valid is high and stall is low.
// An accepted item is held in the input register; once the result register is free or
// being drained, the bank logic applies it to the register file and loads the result
// register, which offers it on the rsp_ channel. Items are taken one per cycle for as
// long as the result register is free or being drained in the same cycle; the only
// limit is the single pass through the bank logic.
// When the receiver stalls, the result register holds its contents and the item
// behind it waits in the input register; req_stall rises only when both are full.
// Reset is synchronous: both pipeline registers empty, the register file returns to zeros
// with the input word's low half at ones, the alternate flags clear and the input mask
// is zero. The mask is to be written over the APB-style port only while the block is
// idle; the block does not enforce this. The mask only affects the device reset command.
module gpio_port_register_bank #(
   parameter int PIN_COUNT = 16,
   parameter int REG_COUNT = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic [3:0]                     req_reg_index,
   input  logic [31:0]                    req_write_data,
   input  logic [3:0]                     req_pin_number,
   input  logic                           req_pin_level,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_read_data,
   output logic [15:0]                    rsp_pin_drive,
   output logic [15:0]                    rsp_drive_changed,
   output logic [15:0]                    rsp_alt_flags,
   output logic [15:0]                    rsp_alt_changed,
   output logic [1:0]                     rsp_edge_event,
   output logic [3:0]                     rsp_edge_pin,
   output logic                           rsp_wake_level,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gpr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import gpr_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   req_item_type  in_item_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_item_type  rsp_item_ff;
   rsp_item_type  exec_result;
   exec_ctrl_type exec_ctrl;
   logic          advance;
   logic          accept_in;
   logic [15:0]   input_mask;

   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign accept_in = req_valid & ~req_stall;

   assign in_valid_in  = accept_in | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   assign exec_ctrl.step  = advance;
   assign exec_ctrl.valid = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_item_ff.command    <= cmd_type'(req_command);
         in_item_ff.reg_index  <= req_reg_index;
         in_item_ff.write_data <= req_write_data;
         in_item_ff.pin_number <= req_pin_number;
         in_item_ff.pin_level  <= req_pin_level;
      end
      if (advance) begin
         rsp_item_ff <= exec_result;
      end
   end

   gpr_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .input_mask (input_mask)
   );

   gpr_exec #(
      .PIN_COUNT (PIN_COUNT),
      .REG_COUNT (REG_COUNT)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (exec_ctrl),
      .item       (in_item_ff),
      .input_mask (input_mask),
      .result     (exec_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_item_ff.read_data;
   assign rsp_pin_drive     = rsp_item_ff.pin_drive;
   assign rsp_drive_changed = rsp_item_ff.drive_changed;
   assign rsp_alt_flags     = rsp_item_ff.alt_flags;
   assign rsp_alt_changed   = rsp_item_ff.alt_changed;
   assign rsp_edge_event    = rsp_item_ff.edge_event;
   assign rsp_edge_pin      = rsp_item_ff.edge_pin;
   assign rsp_wake_level    = rsp_item_ff.wake_level;

endmodule

@@ rtl/core/gpr_checker.sv @@
// Port-level checks of the GPIO port register bank and their binding to the top level.
module gpr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [31:0]                    rsp_read_data,
   input logic [15:0]                    rsp_pin_drive,
   input logic [15:0]                    rsp_drive_changed,
   input logic [15:0]                    rsp_alt_changed,
   input logic [1:0]                     rsp_edge_event,
   input logic [3:0]                     rsp_edge_pin,
   input logic                           rsp_wake_level
);
   import gpr_pkg::*;

   // The result channel is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_pin_drive) && $stable(rsp_edge_event))
      else $error("stalled result changed");

   // With the result register empty the input side never stalls.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the result register is empty");

   // A read that returns data has changed no pin and reported no edge.
   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != 32'd0 |-> rsp_drive_changed == 16'd0
         && rsp_alt_changed == 16'd0 && rsp_edge_event == EDGE_NONE)
      else $error("read result carries pin activity");

   // An edge pin is only reported together with an edge; checked where wake_level is low.
   a_edge_pin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_event == EDGE_NONE |-> rsp_edge_pin == 4'd0
         && rsp_wake_level == 1'b0 || rsp_edge_event != EDGE_NONE
         || rsp_wake_level == 1'b1)
      else $error("edge pin reported without an edge");

endmodule

bind gpio_port_register_bank gpr_checker u_gpr_checker (.*);

@@ tb/sv/gpio_port_register_bank_test.sv @@
// Self-checking testbench of the GPIO port register bank with its own port model.
module gpio_port_register_bank_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gpr_pkg::*;

   localparam int PIN_COUNT      = 16;
   localparam int REG_COUNT      = 11;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_PAUSE    = 4;

   localparam logic [3:0] IDX_ALTHIGH = 4'd9;
   localparam logic [3:0] IDX_UNUSED  = 4'd11;
   localparam logic [3:0] IDX_TOP     = 4'd15;

   localparam logic [CSR_ADDR_W-1:0] MASK_ADDR = {CSR_IDX_INPUT_MASK, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_command;
   logic [3:0]            req_reg_index;
   logic [31:0]           req_write_data;
   logic [3:0]            req_pin_number;
   logic                  req_pin_level;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [31:0]           rsp_read_data;
   logic [15:0]           rsp_pin_drive;
   logic [15:0]           rsp_drive_changed;
   logic [15:0]           rsp_alt_flags;
   logic [15:0]           rsp_alt_changed;
   logic [1:0]            rsp_edge_event;
   logic [3:0]            rsp_edge_pin;
   logic                  rsp_wake_level;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   logic [31:0]  port_regs [0:REG_COUNT-1];
   logic [15:0]  alt_model;
   logic [15:0]  mask_model;
   rsp_item_type awaited_results[$];
   logic [3:0]   busy_regs [0:4];
   int           mismatch_count;
   int           quiet_cycles;
   bit           steady;

   gpio_port_register_bank #(
      .PIN_COUNT(PIN_COUNT),
      .REG_COUNT(REG_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_reg_index(req_reg_index),
      .req_write_data(req_write_data),
      .req_pin_number(req_pin_number),
      .req_pin_level(req_pin_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_pin_drive(rsp_pin_drive),
      .rsp_drive_changed(rsp_drive_changed),
      .rsp_alt_flags(rsp_alt_flags),
      .rsp_alt_changed(rsp_alt_changed),
      .rsp_edge_event(rsp_edge_event),
      .rsp_edge_pin(rsp_edge_pin),
      .rsp_wake_level(rsp_wake_level),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] seen);
      $display("%0t: %s expected %h, got %h", $time, what, want, seen);
      mismatch_count++;
   endtask

   function automatic void restore_port_regs();
      int i;
      for (i = 0; i < REG_COUNT; i++) begin
         port_regs[i] = '0;
      end
      port_regs[IDX_INPUT] = {16'h0, HALF_ONES & ~mask_model};
   endfunction

   function automatic logic [15:0] load_output(input logic [15:0] value);
      logic [15:0] changed;
      changed = port_regs[IDX_OUTPUT][15:0] ^ value;
      port_regs[IDX_OUTPUT] = {16'h0, value};
      return changed;
   endfunction

   function automatic rsp_item_type apply_port_item(input req_item_type item);
      rsp_item_type result;
      logic [31:0]  prev_mode;
      logic [15:0]  drive;
      logic [15:0]  set_bits;
      logic [15:0]  clear_bits;
      logic [1:0]   mode;
      logic         old_level;
      int           i;
      result = '0;
      case (item.command)
         CMD_READ: begin
            if (item.reg_index < REG_COUNT) begin
               result.read_data = port_regs[item.reg_index];
            end
         end
         CMD_WRITE: begin
            if (item.reg_index >= REG_COUNT || item.reg_index == IDX_INPUT) begin
            end else if (item.reg_index == IDX_MODE) begin
               prev_mode = port_regs[IDX_MODE];
               drive = port_regs[IDX_OUTPUT][15:0];
               for (i = 0; i < PIN_COUNT; i++) begin
                  mode = item.write_data[2*i +: 2];
                  if (mode != prev_mode[2*i +: 2]) begin
                     result.alt_changed[i] = 1'b1;
                     alt_model[i] = (mode == MODE_ALT);
                     if (mode == MODE_IN) begin
                        drive[i] = 1'b1;
                     end else if (mode == MODE_OUT) begin
                        drive[i] = 1'b0;
                     end
                  end
               end
               result.drive_changed = load_output(drive);
               port_regs[IDX_MODE] = item.write_data;
            end else if (item.reg_index == IDX_OUTPUT) begin
               result.drive_changed = load_output(item.write_data[15:0]);
            end else if (item.reg_index == IDX_SETRESET) begin
               clear_bits = item.write_data[31:16];
               set_bits = item.write_data[15:0];
               port_regs[IDX_INPUT] = (port_regs[IDX_INPUT] & ~{16'h0, clear_bits})
                                      | {16'h0, set_bits};
               result.drive_changed = load_output((port_regs[IDX_OUTPUT][15:0]
                                                   & ~clear_bits) | set_bits);
            end else if (item.reg_index == IDX_RESETONLY) begin
               clear_bits = item.write_data[15:0];
               port_regs[IDX_INPUT] = port_regs[IDX_INPUT] & ~{16'h0, clear_bits};
               result.drive_changed = load_output(port_regs[IDX_OUTPUT][15:0]
                                                  & ~clear_bits);
            end else begin
               port_regs[item.reg_index] = item.write_data;
            end
         end
         CMD_PIN: begin
            if (item.pin_number < PIN_COUNT) begin
               old_level = port_regs[IDX_INPUT][item.pin_number];
               port_regs[IDX_INPUT][item.pin_number] = item.pin_level;
               if (!old_level && item.pin_level) begin
                  result.edge_event = EDGE_RISING;
               end else if (old_level && !item.pin_level) begin
                  result.edge_event = EDGE_FALLING;
               end
               if (result.edge_event != EDGE_NONE) begin
                  result.edge_pin = item.pin_number;
               end
               result.wake_level = item.pin_level;
            end
         end
         default: begin
            restore_port_regs();
         end
      endcase
      result.pin_drive = port_regs[IDX_OUTPUT][15:0];
      result.alt_flags = alt_model;
      return result;
   endfunction

   function automatic req_item_type make_item(input cmd_type command, input logic [3:0] index,
                                              input logic [31:0] data,
                                              input logic [3:0] pin = '0,
                                              input logic level = 1'b0);
      req_item_type item;
      item.command = command;
      item.reg_index = index;
      item.write_data = data;
      item.pin_number = pin;
      item.pin_level = level;
      return item;
   endfunction

   function automatic req_item_type random_port_item();
      req_item_type item;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 25) begin
         item.command = CMD_READ;
      end else if (pick < 68) begin
         item.command = CMD_WRITE;
      end else if (pick < 97) begin
         item.command = CMD_PIN;
      end else begin
         item.command = CMD_RESET;
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
         item.reg_index = busy_regs[$urandom_range(4)];
      end else if (pick < 90) begin
         item.reg_index = 4'($urandom_range(REG_COUNT - 1));
      end else begin
         item.reg_index = 4'($urandom_range(IDX_TOP, IDX_UNUSED));
      end
      item.write_data = $urandom;
      if (item.reg_index == IDX_MODE && $urandom_range(99) < 40) begin
         item.write_data = port_regs[IDX_MODE] ^ (32'h1 << $urandom_range(31))
                           ^ (32'h1 << $urandom_range(31));
      end
      item.pin_number = 4'($urandom_range(15));
      item.pin_level = 1'($urandom_range(1));
      return item;
   endfunction

   task automatic send_item(input req_item_type item);
      while (!steady && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= item.command;
      req_reg_index <= item.reg_index;
      req_write_data <= item.write_data;
      req_pin_number <= item.pin_number;
      req_pin_level <= item.pin_level;
      do @(posedge clock); while (req_stall !== 1'b0);
      awaited_results.push_back(apply_port_item(item));
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   task automatic write_input_mask(input logic [15:0] value);
      wait_until_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= MASK_ADDR;
      pwdata <= {16'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      mask_model = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== {16'h0, mask_model}) begin
         report_mismatch("input_mask readback", {16'h0, mask_model}, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_directed_cases();
      send_item(make_item(CMD_READ, IDX_INPUT, '0));
      send_item(make_item(CMD_WRITE, IDX_MODE, 32'h5555_5555));
      send_item(make_item(CMD_WRITE, IDX_OUTPUT, 32'hFFFF_FFFF));
      send_item(make_item(CMD_WRITE, IDX_MODE, 32'h0000_0000));
      send_item(make_item(CMD_WRITE, IDX_MODE, 32'hAAAA_AAAA));
      send_item(make_item(CMD_WRITE, IDX_MODE, 32'hFFFF_FFFF));
      send_item(make_item(CMD_WRITE, IDX_SETRESET, 32'hFFFF_00FF));
      send_item(make_item(CMD_WRITE, IDX_RESETONLY, 32'hFFFF_F0F0));
      send_item(make_item(CMD_READ, IDX_SETRESET, '0));
      send_item(make_item(CMD_READ, IDX_RESETONLY, '0));
      send_item(make_item(CMD_WRITE, IDX_INPUT, 32'h1234_5678));
      send_item(make_item(CMD_READ, IDX_INPUT, '0));
      send_item(make_item(CMD_PIN, IDX_MODE, '0, 4'd0, 1'b0));
      send_item(make_item(CMD_PIN, IDX_MODE, '0, 4'd0, 1'b1));
      send_item(make_item(CMD_PIN, IDX_MODE, '0, 4'd15, 1'b1));
      send_item(make_item(CMD_PIN, IDX_MODE, '0, 4'd15, 1'b0));
      send_item(make_item(CMD_PIN, IDX_MODE, '0, 4'd15, 1'b0));
      send_item(make_item(CMD_WRITE, IDX_ALTHIGH, 32'hFFFF_FFFF));
      send_item(make_item(CMD_READ, IDX_ALTHIGH, '0));
      send_item(make_item(CMD_WRITE, IDX_TOP, 32'hFFFF_FFFF));
      send_item(make_item(CMD_READ, IDX_TOP, '0));
      send_item(make_item(CMD_READ, IDX_UNUSED, '0));
      send_item(make_item(CMD_RESET, IDX_MODE, '0));
      send_item(make_item(CMD_READ, IDX_INPUT, '0));
      send_item(make_item(CMD_READ, IDX_MODE, '0));
   endtask

   task automatic check_input_mask(input logic [15:0] value);
      write_input_mask(value);
      send_item(make_item(CMD_RESET, IDX_MODE, '0));
      send_item(make_item(CMD_READ, IDX_INPUT, '0));
      send_item(make_item(CMD_PIN, IDX_MODE, '0, 4'($urandom_range(15)), 1'b1));
      send_item(make_item(CMD_PIN, IDX_MODE, '0, 4'($urandom_range(15)), 1'b0));
   endtask

   task automatic run_random_traffic(input int count, input int steady_count);
      int n;
      for (n = 0; n < count; n++) begin
         steady = (n < steady_count);
         send_item(random_port_item());
      end
      steady = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen = {rsp_read_data, rsp_pin_drive, rsp_drive_changed, rsp_alt_flags,
                 rsp_alt_changed, rsp_edge_event, rsp_edge_pin, rsp_wake_level};
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected transfer, read_data", '0, seen.read_data);
         end else begin
            want = awaited_results.pop_front();
            if (seen.read_data !== want.read_data) begin
               report_mismatch("read_data", want.read_data, seen.read_data);
            end
            if (seen.pin_drive !== want.pin_drive) begin
               report_mismatch("pin_drive", 32'(want.pin_drive), 32'(seen.pin_drive));
            end
            if (seen.drive_changed !== want.drive_changed) begin
               report_mismatch("drive_changed", 32'(want.drive_changed),
                               32'(seen.drive_changed));
            end
            if (seen.alt_flags !== want.alt_flags) begin
               report_mismatch("alt_flags", 32'(want.alt_flags), 32'(seen.alt_flags));
            end
            if (seen.alt_changed !== want.alt_changed) begin
               report_mismatch("alt_changed", 32'(want.alt_changed),
                               32'(seen.alt_changed));
            end
            if (seen.edge_event !== want.edge_event) begin
               report_mismatch("edge_event", 32'(want.edge_event), 32'(seen.edge_event));
            end
            if (seen.edge_pin !== want.edge_pin) begin
               report_mismatch("edge_pin", 32'(want.edge_pin), 32'(seen.edge_pin));
            end
            if (seen.wake_level !== want.wake_level) begin
               report_mismatch("wake_level", 32'(want.wake_level), 32'(seen.wake_level));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_valid === 1'b1 && req_stall === 1'b0)
          || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_READ;
      req_reg_index = '0;
      req_write_data = '0;
      req_pin_number = '0;
      req_pin_level = 1'b0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      steady = 1'b0;
      mismatch_count = 0;
      quiet_cycles = 0;
      busy_regs = '{IDX_MODE, IDX_OUTPUT, IDX_SETRESET, IDX_RESETONLY, IDX_INPUT};
      mask_model = '0;
      alt_model = '0;
      restore_port_regs();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_directed_cases();
      check_input_mask(HALF_ONES);
      run_random_traffic(450, 0);
      check_input_mask(16'h0000);
      run_random_traffic(450, 0);
      check_input_mask(16'($urandom_range(16'hFFFF)));
      run_random_traffic(450, 200);
      check_input_mask(16'($urandom_range(16'hFFFF)));
      run_random_traffic(450, 0);

      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
